@@ sv/message_id_seen_count_table_unit_assert.svh @@
// Assertion macros for the message identifier seen-count table.
// Included by mistc_seq, which checks its own sequencing; no other dependencies.
`ifndef MESSAGE_ID_SEEN_COUNT_TABLE_UNIT_ASSERT_SVH
`define MESSAGE_ID_SEEN_COUNT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define MISTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mistc assertion failed");

// next-cycle implication
`define MISTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mistc assertion failed");

`endif

@@ sv/mistc_pkg.sv @@
// Package for the message identifier seen-count table: word types, sequencer states,
// store write request and the proprietary-range decode. No dependencies.
package mistc_pkg;

    localparam int GROUP_W = 18;
    localparam int SOURCE_W = 8;
    localparam int SLOT_W = 6;
    localparam int TOTAL_W = 32;
    localparam int ADDR_MAX_W = 8;

    localparam logic [GROUP_W-1:0] PROP_SINGLE = 18'd126720;
    localparam logic [GROUP_W-1:0] PROP_A_LO = 18'd65280;
    localparam logic [GROUP_W-1:0] PROP_A_HI = 18'd65535;
    localparam logic [GROUP_W-1:0] PROP_B_LO = 18'd130816;
    localparam logic [GROUP_W-1:0] PROP_B_HI = 18'd131071;

    typedef struct packed {
        logic [GROUP_W-1:0]  group_number;
        logic [SOURCE_W-1:0] source_address;
    } t_in_word;

    typedef struct packed {
        logic               first_seen;
        logic               proprietary;
        logic [SLOT_W-1:0]  slot_index;
        logic [TOTAL_W-1:0] seen_total;
        logic               table_full;
    } t_out_word;

    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] addr;
        logic [GROUP_W-1:0]    group;
        logic [TOTAL_W-1:0]    total;
        logic [SOURCE_W-1:0]   source;
    } t_mem_wr;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [TOTAL_W-1:0] total;
    } t_mem_rd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUSH
    } t_state;

    function automatic logic is_proprietary(input logic [GROUP_W-1:0] g);
        is_proprietary = (g == PROP_SINGLE) ||
                         ((g >= PROP_A_LO) && (g <= PROP_A_HI)) ||
                         ((g >= PROP_B_LO) && (g <= PROP_B_HI));
    endfunction

endpackage

@@ sv/message_id_seen_count_table_unit.sv @@
// Top level of the message identifier seen-count table: scan sequencer and output register.
// Depends on mistc_pkg, mistc_seq and mistc_store.
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+---------------------
//  in       | input     | i_in_valid / o_in_ready | mistc_pkg::t_in_word
//  out      | output    | o_out_valid/ i_out_ready| mistc_pkg::t_out_word
//
// Each entry scanned takes one memory read and one compare; the push then waits for room at the output.
// A hit at entry k ends the scan at that entry; a miss scans all TABLE_ENTRIES entries.
// Reset clears the valid bits at once; no clearing pass.
// A waiting result sits in the output register while the next word is scanned.
module message_id_seen_count_table_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mistc_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mistc_pkg::t_out_word o_out_word
);

    logic                 out_room;
    logic                 push;
    mistc_pkg::t_out_word res;
    logic                 r_out_valid;
    mistc_pkg::t_out_word r_out_word;

    assign out_room = !r_out_valid || i_out_ready;

    mistc_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word (i_in_word),
        .i_out_room(out_room),
        .o_push    (push),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ sv/mistc_store.sv @@
// Entry store of the seen-count table: group, count and last-source memories.
// Depends on mistc_pkg for the write request and read data types.
module mistc_store #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] i_rd_addr,
    input  mistc_pkg::t_mem_wr        i_wr,
    output mistc_pkg::t_mem_rd        o_rd
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [mistc_pkg::GROUP_W-1:0]  r_group_mem  [TABLE_ENTRIES];
    logic [mistc_pkg::TOTAL_W-1:0]  r_total_mem  [TABLE_ENTRIES];
    logic [mistc_pkg::SOURCE_W-1:0] r_source_mem [TABLE_ENTRIES];
    mistc_pkg::t_mem_rd             r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_group_mem[i_wr.addr[IW-1:0]]  <= i_wr.group;
            r_total_mem[i_wr.addr[IW-1:0]]  <= i_wr.total;
            r_source_mem[i_wr.addr[IW-1:0]] <= i_wr.source;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.group <= r_group_mem[i_rd_addr];
        r_rd.total <= r_total_mem[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

@@ sv/mistc_seq.sv @@
// Scan sequencer of the seen-count table: one shared compare over the entries,
// valid bits, first-free tracking and result build. Depends on mistc_pkg and mistc_store.
`include "message_id_seen_count_table_unit_assert.svh"

module mistc_seq #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mistc_pkg::t_in_word  i_in_word,
    input  logic                 i_out_room,
    output logic                 o_push,
    output mistc_pkg::t_out_word o_res
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    mistc_pkg::t_state              r_state, n_state;
    logic [IW-1:0]                  r_idx, n_idx;
    logic                           r_free_found, n_free_found;
    logic [IW-1:0]                  r_free_idx, n_free_idx;
    logic [TABLE_ENTRIES-1:0]       r_valid, n_valid;
    mistc_pkg::t_out_word           r_res, n_res;
    logic [mistc_pkg::GROUP_W-1:0]  r_group;
    logic [mistc_pkg::SOURCE_W-1:0] r_src;

    mistc_pkg::t_mem_wr wr;
    mistc_pkg::t_mem_rd rd;
    logic               hit;
    logic               free_now;
    logic               eff_found;
    logic [IW-1:0]      eff_idx;

    mistc_store #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_store (
        .i_clk    (i_clk),
        .i_rd_addr(r_idx),
        .i_wr     (wr),
        .o_rd     (rd)
    );

    assign hit       = r_valid[r_idx] && (rd.group == r_group);
    assign free_now  = !r_free_found && !r_valid[r_idx];
    assign eff_found = r_free_found || free_now;
    assign eff_idx   = r_free_found ? r_free_idx : r_idx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mistc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = mistc_pkg::S_RD;
            end
            mistc_pkg::S_RD: begin
                n_state = mistc_pkg::S_CMP;
            end
            mistc_pkg::S_CMP: begin
                if (hit || (r_idx == LAST)) n_state = mistc_pkg::S_PUSH;
                else n_state = mistc_pkg::S_RD;
            end
            mistc_pkg::S_PUSH: begin
                if (i_out_room) n_state = mistc_pkg::S_IDLE;
            end
            default: n_state = mistc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_push       = 1'b0;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_res        = r_res;
        wr           = '0;
        unique case (r_state)
            mistc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_free_idx   = '0;
                end
            end
            mistc_pkg::S_RD: begin
            end
            mistc_pkg::S_CMP: begin
                n_res.proprietary = mistc_pkg::is_proprietary(r_group);
                if (hit) begin
                    wr.we    = 1'b1;
                    wr.addr  = mistc_pkg::ADDR_MAX_W'(r_idx);
                    wr.group = r_group;
                    wr.total = rd.total + 32'd1;
                    wr.source = r_src;
                    n_res.first_seen = 1'b0;
                    n_res.table_full = 1'b0;
                    n_res.slot_index = mistc_pkg::SLOT_W'(r_idx);
                    n_res.seen_total = rd.total + 32'd1;
                end else begin
                    if (free_now) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (r_idx == LAST) begin
                        if (eff_found) begin
                            wr.we    = 1'b1;
                            wr.addr  = mistc_pkg::ADDR_MAX_W'(eff_idx);
                            wr.group = r_group;
                            wr.total = 32'd1;
                            wr.source = r_src;
                            n_valid[eff_idx] = 1'b1;
                            n_res.first_seen = 1'b1;
                            n_res.table_full = 1'b0;
                            n_res.slot_index = mistc_pkg::SLOT_W'(eff_idx);
                            n_res.seen_total = 32'd1;
                        end else begin
                            n_res.first_seen = 1'b0;
                            n_res.table_full = 1'b1;
                            n_res.slot_index = '0;
                            n_res.seen_total = '0;
                        end
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            mistc_pkg::S_PUSH: begin
                o_push = i_out_room;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mistc_pkg::S_IDLE;
            r_idx        <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_valid      <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (o_in_ready && i_in_valid) begin
            r_group <= i_in_word.group_number;
            r_src   <= i_in_word.source_address;
        end
    end

    assign o_res = r_res;

    `MISTC_ASSERT_NOW(a_wr_in_cmp, i_clk, i_rst_n, wr.we, r_state == mistc_pkg::S_CMP)
    `MISTC_ASSERT_NEXT(a_push_to_idle, i_clk, i_rst_n, o_push, r_state == mistc_pkg::S_IDLE)
    `MISTC_ASSERT_NEXT(a_valid_grow, i_clk, i_rst_n, 1'b1,
        $countones(r_valid) >= $countones($past(r_valid)))
    `MISTC_ASSERT_NOW(a_full_no_wr, i_clk, i_rst_n, n_res.table_full && (r_state == mistc_pkg::S_CMP), !wr.we)

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for message_id_seen_count_table_unit: directed and random
// message words against a behavioural model of the seen-count table.
// Depends on mistc_pkg and the RTL under sv/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 64;
    localparam int RANDOM_WORDS = 880;
    localparam int STALL_LIMIT = 4000;
    localparam logic [17:0] OWN_SINGLE = 18'd126720;
    localparam logic [17:0] OWN_A_FIRST = 18'd65280;
    localparam logic [17:0] OWN_A_LAST = 18'd65535;
    localparam logic [17:0] OWN_B_FIRST = 18'd130816;
    localparam logic [17:0] OWN_B_LAST = 18'd131071;

    class seen_count_book;
        bit                   known_valid [TABLE_ENTRIES];
        logic [17:0]          known_group [TABLE_ENTRIES];
        logic [31:0]          known_count [TABLE_ENTRIES];
        logic [7:0]           known_source [TABLE_ENTRIES];
        mistc_pkg::t_out_word pending_results [$];
        int                   faults;

        function void take_message(mistc_pkg::t_in_word w);
            mistc_pkg::t_out_word want;
            int hit;
            int spot;
            hit = -1;
            spot = -1;
            want = '0;
            want.proprietary = (w.group_number == OWN_SINGLE) ||
                (w.group_number >= OWN_A_FIRST && w.group_number <= OWN_A_LAST) ||
                (w.group_number >= OWN_B_FIRST && w.group_number <= OWN_B_LAST);
            for (int k = 0; k < TABLE_ENTRIES && hit < 0; k++) begin
                if (known_valid[k] && known_group[k] == w.group_number) begin
                    hit = k;
                end
            end
            if (hit >= 0) begin
                known_count[hit] = known_count[hit] + 32'd1;
                known_source[hit] = w.source_address;
                want.slot_index = 6'(hit);
                want.seen_total = known_count[hit];
            end else begin
                for (int k = 0; k < TABLE_ENTRIES && spot < 0; k++) begin
                    if (!known_valid[k]) begin
                        spot = k;
                    end
                end
                if (spot >= 0) begin
                    known_valid[spot] = 1'b1;
                    known_group[spot] = w.group_number;
                    known_count[spot] = 32'd1;
                    known_source[spot] = w.source_address;
                    want.first_seen = 1'b1;
                    want.slot_index = 6'(spot);
                    want.seen_total = 32'd1;
                end else begin
                    want.table_full = 1'b1;
                end
            end
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s expected %0d got %0d", name, want, got);
                faults++;
            end
        endfunction

        function void check_result(mistc_pkg::t_out_word got);
            mistc_pkg::t_out_word want;
            if (pending_results.size() == 0) begin
                $error("result word %h with nothing awaited", got);
                faults++;
            end else begin
                want = pending_results.pop_front();
                compare_field("first_seen", 32'(want.first_seen), 32'(got.first_seen));
                compare_field("proprietary", 32'(want.proprietary), 32'(got.proprietary));
                compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
                compare_field("seen_total", want.seen_total, got.seen_total);
                compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    mistc_pkg::t_in_word  i_in_word;
    logic                 o_out_valid;
    logic                 i_out_ready;
    mistc_pkg::t_out_word o_out_word;

    seen_count_book book;
    bit             steady;
    logic [17:0]    sent_groups [$];

    message_id_seen_count_table_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [17:0] boundary_group(int k);
        case (k)
            0: return 18'd0;
            1: return 18'd1;
            2: return 18'd65279;
            3: return 18'd65280;
            4: return 18'd65535;
            5: return 18'd65536;
            6: return 18'd126719;
            7: return 18'd126720;
            8: return 18'd126721;
            9: return 18'd130815;
            10: return 18'd130816;
            11: return 18'd131071;
            12: return 18'd131072;
            13: return 18'd262142;
            default: return 18'd262143;
        endcase
    endfunction

    task automatic send_word(input logic [17:0] group, input logic [7:0] source);
        mistc_pkg::t_in_word w;
        w.group_number = group;
        w.source_address = source;
        while (!steady && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        book.take_message(w);
        sent_groups.push_back(group);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // result side
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                book.check_result(o_out_word);
            end
            i_out_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("message_id_seen_count_table_unit verification failed");
        $finish;
    end

    initial begin
        int pick;
        logic [17:0] group;
        book = new;
        steady = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 15; k++) begin
            send_word(boundary_group(k), (k % 2 == 0) ? 8'h00 : 8'hFF);
        end
        send_word(18'd0, 8'hFF);
        send_word(18'd126720, 8'($urandom_range(255)));
        send_word(18'd262143, 8'h00);
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = (n >= 400 && n < 550);
            if (n == 300) begin
                drain();
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                group = sent_groups[$urandom_range(sent_groups.size() - 1)];
            end else if (pick < 75) begin
                group = 18'($urandom_range(262143));
            end else if (pick < 88) begin
                case ($urandom_range(2))
                    0: group = OWN_SINGLE;
                    1: group = OWN_A_FIRST + 18'($urandom_range(255));
                    default: group = OWN_B_FIRST + 18'($urandom_range(255));
                endcase
            end else begin
                group = boundary_group($urandom_range(14));
            end
            send_word(group, 8'($urandom_range(255)));
        end
        steady = 1'b0;

        drain();
        repeat (2 * TABLE_ENTRIES + 8) @(posedge i_clk);
        if (book.faults == 0) begin
            $display("message_id_seen_count_table_unit verification clean");
        end else begin
            $display("message_id_seen_count_table_unit verification failed");
        end
        $finish;
    end
endmodule
